FILE: rtl/core/radial_ramp_kernel_generator_defines.svh
`ifndef RADIAL_RAMP_KERNEL_GENERATOR_DEFINES_SVH
`define RADIAL_RAMP_KERNEL_GENERATOR_DEFINES_SVH

// same-cycle implication check
`define RRKG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrkg check failed");

// next-cycle implication check
`define RRKG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrkg check failed");

`endif

FILE: rtl/core/rrkg_pkg.sv
`default_nettype none

package rrkg_pkg;

  localparam logic [2:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_SHAPE_MODE   = 3'd2;
  localparam logic [2:0] REG_INNER_RADIUS = 3'd3;
  localparam logic [2:0] REG_OUTER_RADIUS = 3'd4;
  localparam logic [2:0] REG_BORDER_WIDTH = 3'd5;

  localparam logic [10:0] RST_GRID_WIDTH   = 11'd64;
  localparam logic [10:0] RST_GRID_HEIGHT  = 11'd64;
  localparam logic        RST_SHAPE_MODE   = 1'b0;
  localparam logic [15:0] RST_INNER_RADIUS = 16'd448;
  localparam logic [15:0] RST_OUTER_RADIUS = 16'd1344;
  localparam logic [15:0] RST_BORDER_WIDTH = 16'd64;

  localparam logic        SHAPE_DISC = 1'b0;
  localparam logic        SHAPE_RING = 1'b1;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [4:0]  LAST_STEP = 5'd16;

  typedef struct packed {
    logic load_in;
    logic calc_sq;
    logic sqrt_init;
    logic sqrt_step;
    logic ramp_init;
    logic div_step;
    logic ramp_save;
    logic rsel;
    logic calc_w;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic ring;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/rrkg_datapath.sv
`default_nettype none

module rrkg_datapath #(
  parameter int MAX_DIM = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [2:0]           cfg_index,
  input  wire [15:0]          cfg_data,
  input  wire [9:0]           in_col,
  input  wire [9:0]           in_row,
  input  wire                 in_first,
  input  wire rrkg_pkg::cmd_t cmd,
  output rrkg_pkg::sts_t      sts,
  output logic [16:0]         out_weight,
  output logic [36:0]         out_weight_sum
);

  logic [10:0] grid_width_r, grid_height_r;
  logic        shape_mode_r;
  logic [15:0] inner_radius_r, outer_radius_r, border_width_r;

  logic [9:0]  col_r, row_r;
  logic        first_r;
  logic [20:0] sq_r, sq_nxt;
  logic [32:0] rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] drem_r, drem_nxt;
  logic [16:0] dq_r, dq_nxt;
  logic        rconst_r, rconst_nxt;
  logic [16:0] rval_r, rval_nxt;
  logic [16:0] ri_r, ri_nxt, ro_r, ro_nxt;
  logic [16:0] w_r, w_nxt;
  logic [16:0] wout_r, wout_nxt;
  logic [36:0] sum_r, sum_nxt;

  logic [10:0]        gw_c, gh_c;
  logic signed [10:0] dx, dy;
  logic signed [21:0] dxx, dyy;
  logic [33:0]        trial_sq;
  logic               ge_sq;
  logic [15:0]        rad;
  logic signed [19:0] d2, lo, hi, diff;
  logic               below, above;
  logic [16:0]        trial_dv;
  logic               ge_dv;
  logic [16:0]        ramp_val;
  logic [33:0]        prod;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= rrkg_pkg::RST_GRID_WIDTH;
      grid_height_r  <= rrkg_pkg::RST_GRID_HEIGHT;
      shape_mode_r   <= rrkg_pkg::RST_SHAPE_MODE;
      inner_radius_r <= rrkg_pkg::RST_INNER_RADIUS;
      outer_radius_r <= rrkg_pkg::RST_OUTER_RADIUS;
      border_width_r <= rrkg_pkg::RST_BORDER_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrkg_pkg::REG_GRID_WIDTH:   grid_width_r   <= cfg_data[10:0];
        rrkg_pkg::REG_GRID_HEIGHT:  grid_height_r  <= cfg_data[10:0];
        rrkg_pkg::REG_SHAPE_MODE:   shape_mode_r   <= cfg_data[0];
        rrkg_pkg::REG_INNER_RADIUS: inner_radius_r <= cfg_data;
        rrkg_pkg::REG_OUTER_RADIUS: outer_radius_r <= cfg_data;
        rrkg_pkg::REG_BORDER_WIDTH: border_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // centre offsets and squared distance
  always_comb begin
    gw_c = ({21'd0, grid_width_r} > 32'(MAX_DIM)) ? 11'(MAX_DIM) : grid_width_r;
    gh_c = ({21'd0, grid_height_r} > 32'(MAX_DIM)) ? 11'(MAX_DIM) : grid_height_r;
    dx   = $signed({1'b0, col_r}) - $signed({1'b0, gw_c[10:1]});
    dy   = $signed({1'b0, row_r}) - $signed({1'b0, gh_c[10:1]});
    dxx  = dx * dx;
    dyy  = dy * dy;
    sq_nxt = cmd.calc_sq ? ({1'b0, dxx[19:0]} + {1'b0, dyy[19:0]}) : sq_r;
  end

  // bit-serial square root
  always_comb begin
    trial_sq = {1'b0, root_r} + {1'b0, bit_r};
    ge_sq    = {1'b0, rem_r} >= trial_sq;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    if (cmd.sqrt_init) begin
      rem_nxt  = {sq_r, 12'd0};
      root_nxt = '0;
      bit_nxt  = {1'b1, 32'd0};
    end else if (cmd.sqrt_step) begin
      if (ge_sq) begin
        rem_nxt  = rem_r - trial_sq[32:0];
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  // ramp classification and restoring division
  always_comb begin
    rad   = cmd.rsel ? outer_radius_r : inner_radius_r;
    d2    = $signed({2'b00, root_r[16:0], 1'b0});
    lo    = $signed({3'b000, rad, 1'b0}) - $signed({4'b0000, border_width_r});
    hi    = $signed({3'b000, rad, 1'b0}) + $signed({4'b0000, border_width_r});
    below = d2 < lo;
    above = d2 > hi;
    diff  = d2 - lo;

    trial_dv = {drem_r, dq_r[16]};
    ge_dv    = trial_dv >= {1'b0, border_width_r};

    drem_nxt   = drem_r;
    dq_nxt     = dq_r;
    rconst_nxt = rconst_r;
    rval_nxt   = rval_r;
    if (cmd.ramp_init) begin
      drem_nxt   = {1'b0, diff[16:2]};
      dq_nxt     = {diff[1:0], 15'd0};
      rconst_nxt = below || above || (border_width_r == 16'd0);
      rval_nxt   = above ? rrkg_pkg::ONE_Q16 : 17'd0;
    end else if (cmd.div_step) begin
      drem_nxt = ge_dv ? 16'(trial_dv - {1'b0, border_width_r}) : trial_dv[15:0];
      dq_nxt   = {dq_r[15:0], ge_dv};
    end
  end

  // shared step counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.sqrt_init || cmd.ramp_init) begin
      cnt_nxt = '0;
    end else if (cmd.sqrt_step || cmd.div_step) begin
      cnt_nxt = cnt_r + 5'd1;
    end
  end

  // ramp results, weight and running sum
  always_comb begin
    ramp_val = rconst_r ? rval_r : dq_r;
    ri_nxt   = (cmd.ramp_save && !cmd.rsel) ? ramp_val : ri_r;
    ro_nxt   = (cmd.ramp_save && cmd.rsel) ? ramp_val : ro_r;
    prod     = ri_r * (rrkg_pkg::ONE_Q16 - ro_r);
    w_nxt    = w_r;
    if (cmd.calc_w) begin
      w_nxt = (shape_mode_r == rrkg_pkg::SHAPE_RING) ? prod[32:16]
                                                     : rrkg_pkg::ONE_Q16 - ri_r;
    end
    wout_nxt = cmd.out_load ? w_r : wout_r;
    sum_nxt  = cmd.out_load ? ((first_r ? 37'd0 : sum_r) + {20'd0, w_r}) : sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_r   <= in_col;
      row_r   <= in_row;
      first_r <= in_first;
    end
    sq_r     <= sq_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    bit_r    <= bit_nxt;
    drem_r   <= drem_nxt;
    dq_r     <= dq_nxt;
    rconst_r <= rconst_nxt;
    rval_r   <= rval_nxt;
    ri_r     <= ri_nxt;
    ro_r     <= ro_nxt;
    w_r      <= w_nxt;
    wout_r   <= wout_nxt;
  end

  assign sts = '{last_step: (cnt_r == rrkg_pkg::LAST_STEP),
                 ring:      (shape_mode_r == rrkg_pkg::SHAPE_RING)};
  assign out_weight       = wout_r;
  assign out_weight_sum   = sum_r;

endmodule

`default_nettype wire

FILE: rtl/core/rrkg_ctrl.sv
`default_nettype none

module rrkg_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  wire rrkg_pkg::sts_t sts,
  output rrkg_pkg::cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SQ    = 12'b000000000010,
    S_RINIT = 12'b000000000100,
    S_ROOT  = 12'b000000001000,
    S_RMP_I = 12'b000000010000,
    S_DIV_I = 12'b000000100000,
    S_SAV_I = 12'b000001000000,
    S_RMP_O = 12'b000010000000,
    S_DIV_O = 12'b000100000000,
    S_SAV_O = 12'b001000000000,
    S_WGT   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        cmd.calc_sq = 1'b1;
        state_nxt   = S_RINIT;
      end
      S_RINIT: begin
        cmd.sqrt_init = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.last_step) state_nxt = S_RMP_I;
      end
      S_RMP_I: begin
        cmd.ramp_init = 1'b1;
        state_nxt     = S_DIV_I;
      end
      S_DIV_I: begin
        cmd.div_step = 1'b1;
        if (sts.last_step) state_nxt = S_SAV_I;
      end
      S_SAV_I: begin
        cmd.ramp_save = 1'b1;
        state_nxt     = sts.ring ? S_RMP_O : S_WGT;
      end
      S_RMP_O: begin
        cmd.ramp_init = 1'b1;
        cmd.rsel      = 1'b1;
        state_nxt     = S_DIV_O;
      end
      S_DIV_O: begin
        cmd.div_step = 1'b1;
        cmd.rsel     = 1'b1;
        if (sts.last_step) state_nxt = S_SAV_O;
      end
      S_SAV_O: begin
        cmd.ramp_save = 1'b1;
        cmd.rsel      = 1'b1;
        state_nxt     = S_WGT;
      end
      S_WGT: begin
        cmd.calc_w = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/radial_ramp_kernel_generator.sv
// radial ramp kernel generator
// input channel: in_valid / in_ready with in_col, in_row, in_first; one item per pixel.
// in_first clears the running sum before this item's weight is added.
// result channel: out_valid / out_ready with out_weight (q1.16) and out_weight_sum.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high; registers are to be written only while no item is in flight (the block does not enforce this).
// the 17-step square root and one (disc) or two (ring) 17-step divisions run on a single
// shared datapath, so one item is processed at a time; the next is accepted only after
// the current result has been loaded into the output register.
// a finished result sits in the output register; the next item is accepted meanwhile
// and, if the receiver still stalls, waits in its final state until the register frees.
// reset (synchronous, rst_n low) returns the registers to their defaults, clears the
// running sum and drops out_valid.
`default_nettype none

module radial_ramp_kernel_generator #(
  parameter int MAX_DIM = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [9:0]  in_col,
  input  wire  [9:0]  in_row,
  input  wire         in_first,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [16:0] out_weight,
  output logic [36:0] out_weight_sum
);

  rrkg_pkg::cmd_t cmd;
  rrkg_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rrkg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrkg_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_first       (in_first),
    .cmd            (cmd),
    .sts            (sts),
    .out_weight     (out_weight),
    .out_weight_sum (out_weight_sum)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rrkg_checker.sv
`default_nettype none

`include "radial_ramp_kernel_generator_defines.svh"

module rrkg_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [16:0] out_weight,
  input wire [36:0] out_weight_sum
);

  // stalled result holds
  `RRKG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_weight) && $stable(out_weight_sum))

  // weight never above one
  `RRKG_ASSERT_NOW(a_weight_range, clk, rst_n, out_valid, out_weight <= 17'h10000)

  // one item at a time
  `RRKG_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind radial_ramp_kernel_generator rrkg_checker u_rrkg_checker (.*);

`default_nettype wire
